/* design/b64e_pkg.sv */
// Package for the Base64 stream encoder: transaction payload types, the
// command record passed from front to back, and the alphabet lookup.
// No dependencies.
`default_nettype none
package b64e_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       end_of_text;
  } out_t;

  localparam int unsigned MaxChars  = 4;
  localparam int unsigned CharIdxW  = $clog2(MaxChars);
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QAddrW    = $clog2(QDepth);
  localparam int unsigned QCountW   = $clog2(QDepth + 1);

  localparam logic [6:0] CharUpperA = 7'd65;
  localparam logic [6:0] CharLowerA = 7'd97;
  localparam logic [6:0] CharZero   = 7'd48;
  localparam logic [6:0] CharPlus   = 7'd43;
  localparam logic [6:0] CharSlash  = 7'd47;
  localparam logic [6:0] PadChar    = 7'd61;

  typedef struct packed {
    logic [MaxChars-1:0][6:0] chars;
    logic [CharIdxW-1:0]      last_idx;
    logic                     fin;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [6:0] sextet_to_char(input logic [5:0] s);
    logic [6:0] s7;
    s7 = {1'b0, s};
    if (s < 6'd26) begin
      return CharUpperA + s7;
    end else if (s < 6'd52) begin
      return CharLowerA + s7 - 7'd26;
    end else if (s < 6'd62) begin
      return CharZero + s7 - 7'd52;
    end else if (s == 6'd62) begin
      return CharPlus;
    end else begin
      return CharSlash;
    end
  endfunction

endpackage
`default_nettype wire

/* design/b64e_front.sv */
// Front end of the Base64 encoder: accepts bytes, tracks group phase and
// residual bits, and builds one character command per byte.
// Depends on b64e_pkg.
`default_nettype none
module b64e_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire b64e_pkg::in_t   in_data_i,
  input  wire b64e_pkg::qstat_t qstat_i,
  output logic                 cmd_push_o,
  output b64e_pkg::cmd_t       cmd_o
);
  import b64e_pkg::*;

  typedef enum logic [2:0] {
    Phase0 = 3'b001,
    Phase1 = 3'b010,
    Phase2 = 3'b100
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] res_q, res_d;
  logic [7:0] b;
  logic       fin;

  assign b          = in_data_i.data_byte;
  assign fin        = in_data_i.final_byte;
  assign cmd_push_o = push_i && !qstat_i.full;

  always_comb begin
    cmd_o.chars    = {MaxChars{PadChar}};
    cmd_o.last_idx = '0;
    cmd_o.fin      = fin;
    phase_d        = Phase0;
    res_d          = '0;
    unique case (phase_q)
      Phase1: begin
        cmd_o.chars[0] = sextet_to_char({res_q[1:0], b[7:4]});
        if (fin) begin
          cmd_o.chars[1] = sextet_to_char({b[3:0], 2'b00});
          cmd_o.last_idx = CharIdxW'(2);
        end else begin
          res_d   = b[3:0];
          phase_d = Phase2;
        end
      end
      Phase2: begin
        cmd_o.chars[0] = sextet_to_char({res_q[3:0], b[7:6]});
        cmd_o.chars[1] = sextet_to_char(b[5:0]);
        cmd_o.last_idx = CharIdxW'(1);
      end
      default: begin
        cmd_o.chars[0] = sextet_to_char(b[7:2]);
        if (fin) begin
          cmd_o.chars[1] = sextet_to_char({b[1:0], 4'b0000});
          cmd_o.last_idx = CharIdxW'(3);
        end else begin
          res_d   = {2'b00, b[1:0]};
          phase_d = Phase1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= Phase0;
      res_q   <= '0;
    end else if (cmd_push_o) begin
      phase_q <= phase_d;
      res_q   <= res_d;
    end
  end

endmodule
`default_nettype wire

/* design/b64e_queue.sv */
// Short command queue between the encoder front and back ends.
// Depends on b64e_pkg.
`default_nettype none
module b64e_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire b64e_pkg::cmd_t   wdata_i,
  input  wire logic             pop_i,
  output b64e_pkg::cmd_t        rdata_o,
  output b64e_pkg::qstat_t      qstat_o
);
  import b64e_pkg::*;

  cmd_t               mem_q [QDepth];
  logic [QAddrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCountW-1:0] count_q, count_d;

  assign qstat_o.full  = (count_q == QCountW'(QDepth));
  assign qstat_o.empty = (count_q == '0);
  assign rdata_o       = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= QAddrW'((wr_ptr_q == QAddrW'(QDepth - 1)) ? 0 : wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= QAddrW'((rd_ptr_q == QAddrW'(QDepth - 1)) ? 0 : rd_ptr_q + 1'b1);
      end
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCountW'(QDepth)) else $error("queue count exceeds depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0) else $error("queue popped while empty");

endmodule
`default_nettype wire

/* design/b64e_back.sv */
// Back end of the Base64 encoder: walks each queued command one character
// per cycle into the output register unless stalled. Depends on b64e_pkg.
`default_nettype none
module b64e_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire b64e_pkg::cmd_t   cmd_i,
  input  wire b64e_pkg::qstat_t qstat_i,
  output logic                  cmd_pop_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output b64e_pkg::out_t        out_data_o
);
  import b64e_pkg::*;

  logic                out_valid_q;
  out_t                out_q;
  logic [CharIdxW-1:0] idx_q;
  logic                advance;
  logic                take;
  logic                at_last;

  assign advance    = !out_valid_q || pop_i;
  assign take       = advance && !qstat_i.empty;
  assign at_last    = (idx_q == cmd_i.last_idx);
  assign cmd_pop_o  = take && at_last;
  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.out_char    <= cmd_i.chars[idx_q];
      out_q.end_of_text <= cmd_i.fin && at_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= take;
      end
      if (take) begin
        idx_q <= at_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  a_idx_in_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !qstat_i.empty |-> idx_q <= cmd_i.last_idx) else $error("index past command end");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> out_valid_q && $stable(out_q))
    else $error("output changed while stalled");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat_i.empty |-> idx_q == '0) else $error("index nonzero with empty queue");

endmodule
`default_nettype wire

/* design/base64_stream_encoder.sv */
// Top level of the Base64 stream encoder: front end, command queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
// Usage:
//   Input channel: one message byte per transaction, with final_byte set on
//   the last byte. A transaction is taken when push is high and full is low.
//   Output channel: one ASCII character per transaction (RFC 4648 alphabet
//   or '=' padding); end_of_text marks the last character of a message.
//   The character on out_data_o is valid while empty is low and is taken
//   when pop is high.
//   Path: a taken byte's command is written into the command queue, and
//   its characters are then loaded one by one into the output register.
//   Throughput: one character per cycle unless the receiver stalls, set by
//   the single output register. A byte yields one or two characters
//   mid-message and up to four on the final byte, so bytes are taken at
//   up to one per cycle while full is low, but not sustained at that rate.
//   A two-entry command queue decouples input from output; when the
//   receiver stalls the output holds, the queue fills and full rises.
//   Reset clears the group phase and residual bits, empties the queue and
//   drops any pending character.
`default_nettype none
module base64_stream_encoder (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire b64e_pkg::in_t  in_data_i,
  output logic                empty,
  input  wire logic           pop,
  output b64e_pkg::out_t      out_data_o
);
  import b64e_pkg::*;

  qstat_t qstat;
  cmd_t   cmd_in;
  cmd_t   cmd_out;
  logic   cmd_push;
  logic   cmd_pop;

  assign full = qstat.full;

  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .qstat_i    (qstat),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  b64e_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .qstat_o (qstat)
  );

  b64e_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_out),
    .qstat_i    (qstat),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire
